>>> design/tesp_pkg.sv
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared types and constants for the terminal escape sequence parser: the
// display action codes, the input word and the result word.
// ----------------------------------------------------------------------------
package tesp_pkg;

	// Field widths of the stream words
	localparam int CHAR_W   = 8;
	localparam int COL_W    = 8;
	localparam int ATTR_W   = 16;
	localparam int ARG_W    = 16;
	localparam int ACTION_W = 5;
	localparam int SO_ATTR_W = 8;

	// Display action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE       = 5'd0,
		ACT_WRITE      = 5'd1,
		ACT_FONT       = 5'd2,
		ACT_TAB        = 5'd3,
		ACT_BACKSPACE  = 5'd4,
		ACT_CR         = 5'd5,
		ACT_LF         = 5'd6,
		ACT_BEEP       = 5'd7,
		ACT_CLEAR_HOME = 5'd8,
		ACT_CUR_UP     = 5'd9,
		ACT_CUR_DOWN   = 5'd10,
		ACT_CUR_RIGHT  = 5'd11,
		ACT_CUR_LEFT   = 5'd12,
		ACT_CUR_MOVE   = 5'd13,
		ACT_CLR_SCREEN = 5'd14,
		ACT_CLR_LINE   = 5'd15,
		ACT_INS_LINES  = 5'd16,
		ACT_DEL_LINES  = 5'd17,
		ACT_DEL_CHARS  = 5'd18,
		ACT_SCROLL_UP  = 5'd19,
		ACT_SCROLL_DN  = 5'd20,
		ACT_SET_ATTR   = 5'd21,
		ACT_INS_CHARS  = 5'd22,
		ACT_BEEP_SET   = 5'd23
	} action_t;

	// One input word
	typedef struct packed {
		logic [ATTR_W-1:0] normal_attr;
		logic [COL_W-1:0]  cursor_column;
		logic [CHAR_W-1:0] char_code;
	} tesp_item_t;

	// One result word
	typedef struct packed {
		logic              scroll_check;
		logic [ATTR_W-1:0] out_attr;
		logic [CHAR_W-1:0] out_char;
		logic [ARG_W-1:0]  arg_two;
		logic [ARG_W-1:0]  arg_one;
		action_t           action;
	} tesp_result_t;

endpackage

>>> design/tesp_core.sv
// ----------------------------------------------------------------------------
// tesp_core
// Parser state and combinational decode: turns one registered character into
// one display action and advances the escape state when the word moves on.
// ----------------------------------------------------------------------------
module tesp_core
	import tesp_pkg::*;
#(
	parameter int PARAM_COUNT = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tesp_item_t   item,
	input  logic         fire,
	output tesp_result_t result
);

	localparam int IDX_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARAM_COUNT - 1);
	localparam logic [ARG_W-1:0] ARG_MAX = '1;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SO    = 8'h0E;
	localparam logic [CHAR_W-1:0] CH_SI    = 8'h0F;
	localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63;
	localparam logic [CHAR_W-1:0] CH_LC_M  = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_LC_R  = 8'h72;
	localparam logic [3:0]        NIBBLE_MASK = 4'hF;
	localparam logic [3:0]        TAB_STOP    = 4'd8;

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2
	} phase_t;

	// Final letter of a CSI sequence to its action
	function automatic action_t csi_code(input logic [CHAR_W-1:0] c);
		action_t a;
		case (c)
			8'h41:        a = ACT_CUR_UP;
			8'h42:        a = ACT_CUR_DOWN;
			8'h43:        a = ACT_CUR_RIGHT;
			8'h44:        a = ACT_CUR_LEFT;
			8'h48, 8'h66: a = ACT_CUR_MOVE;
			8'h4A:        a = ACT_CLR_SCREEN;
			8'h4B:        a = ACT_CLR_LINE;
			8'h4C:        a = ACT_INS_LINES;
			8'h4D:        a = ACT_DEL_LINES;
			8'h50:        a = ACT_DEL_CHARS;
			8'h53:        a = ACT_SCROLL_UP;
			8'h54:        a = ACT_SCROLL_DN;
			8'h78:        a = ACT_SET_ATTR;
			8'h40:        a = ACT_INS_CHARS;
			8'h21:        a = ACT_BEEP_SET;
			default:      a = ACT_NONE;
		endcase
		return a;
	endfunction

	phase_t                 phase_q, phase_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [ARG_W-1:0]       params_q [PARAM_COUNT];
	logic [ARG_W-1:0]       params_d [PARAM_COUNT];
	logic                   so_on_q, so_on_d;
	logic [SO_ATTR_W-1:0]   so_attr_q, so_attr_d;

	logic [CHAR_W-1:0]      ch;
	logic [ARG_W-1:0]       cur_param;
	logic [ARG_W+3:0]       acc;
	logic                   wr;
	logic [ATTR_W-1:0]      wr_attr;
	logic [ATTR_W-1:0]      so_attr_wide;
	action_t                code;
	tesp_result_t           res;

	assign ch           = item.char_code;
	assign cur_param    = params_q[idx_q];
	assign so_attr_wide = ATTR_W'(so_attr_q);
	assign code         = csi_code(ch);

	// Parameter times ten plus the new digit
	assign acc = {1'b0, cur_param, 3'b000} + {3'b000, cur_param, 1'b0}
		+ (ARG_W+4)'(ch[3:0]);

	// Decode the character against the parser state
	always_comb begin
		res              = '0;
		res.action       = ACT_NONE;
		res.scroll_check = 1'b1;
		wr               = 1'b0;
		wr_attr          = '0;
		phase_d          = phase_q;
		idx_d            = idx_q;
		params_d         = params_q;
		so_on_d          = so_on_q;
		so_attr_d        = so_attr_q;

		case (ch)
			CH_SO: begin
				res.action  = ACT_FONT;
				res.arg_one = ARG_W'(2);
			end
			CH_SI: begin
				res.action  = ACT_FONT;
				res.arg_one = ARG_W'(1);
			end
			CH_ESC: begin
				if (phase_q == PH_ESC || phase_q == PH_CSI) begin
					wr      = 1'b1;
					wr_attr = so_attr_wide;
				end else begin
					phase_d = PH_ESC;
				end
			end
			CH_TAB: begin
				res.action  = ACT_TAB;
				res.arg_one = ARG_W'(TAB_STOP - {1'b0, item.cursor_column[2:0]});
			end
			CH_BS: begin
				res.action  = ACT_BACKSPACE;
				res.arg_one = ARG_W'(1);
			end
			CH_CR:  res.action = ACT_CR;
			CH_LF:  res.action = ACT_LF;
			CH_BEL: res.action = ACT_BEEP;
			default: begin
				case (phase_q)
					PH_ESC: begin
						if (ch == CH_LBRK) begin
							phase_d  = PH_CSI;
							params_d = '{default: '0};
							idx_d    = '0;
						end else if (ch == CH_LC_C) begin
							res.action = ACT_CLEAR_HOME;
							phase_d    = PH_NONE;
						end else begin
							phase_d = PH_NONE;
							wr      = 1'b1;
							wr_attr = so_attr_wide;
						end
					end
					PH_CSI: begin
						if (ch inside {[CH_ZERO:CH_NINE]}) begin
							params_d[idx_q] = (acc[ARG_W+3:ARG_W] != '0) ?
								ARG_MAX : acc[ARG_W-1:0];
						end else if (ch == CH_SEMI) begin
							if (idx_q >= IDX_LAST) begin
								phase_d = PH_NONE;
								wr      = 1'b1;
								wr_attr = so_attr_wide;
							end else begin
								idx_d                          = idx_q + 1'b1;
								params_d[IDX_W'(idx_q + 1'b1)] = '0;
							end
						end else if (ch inside {[CH_SPACE:CH_TILDE]}) begin
							if (code != ACT_NONE) begin
								res.action  = code;
								res.arg_one = params_q[0];
								res.arg_two = params_q[1];
								if (code inside {[ACT_CUR_UP:ACT_CUR_LEFT]}) begin
									res.scroll_check = 1'b0;
								end
							end else if (ch == CH_LC_M) begin
								so_on_d = (params_q[0] != '0);
							end else if (ch == CH_LC_R) begin
								so_attr_d = {params_q[1][3:0] & NIBBLE_MASK,
									params_q[0][3:0] & NIBBLE_MASK};
							end else begin
								wr      = 1'b1;
								wr_attr = so_attr_wide;
							end
							phase_d = PH_NONE;
							idx_d   = '0;
						end
					end
					default: begin
						wr      = 1'b1;
						wr_attr = so_on_q ? so_attr_wide : item.normal_attr;
					end
				endcase
			end
		endcase

		if (wr) begin
			res.action   = ACT_WRITE;
			res.out_char = ch;
			res.out_attr = wr_attr;
		end
	end

	assign result = res;

	// Advance the parser state as the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_NONE;
			idx_q     <= '0;
			params_q  <= '{default: '0};
			so_on_q   <= 1'b0;
			so_attr_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			params_q  <= params_d;
			so_on_q   <= so_on_d;
			so_attr_q <= so_attr_d;
		end
	end

`ifndef SYNTHESIS
	// Parameter slot index stays within the parameter store
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("parameter index out of range");

	// Only the cursor moves skip the scroll check
	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		!res.scroll_check |-> (res.action == ACT_CUR_UP || res.action == ACT_CUR_DOWN
			|| res.action == ACT_CUR_RIGHT || res.action == ACT_CUR_LEFT))
		else $error("scroll check dropped on a non-cursor action");

	// Character and attribute are only carried by a write
	a_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		res.action != ACT_WRITE |-> (res.out_char == '0 && res.out_attr == '0))
		else $error("character or attribute on a non-write action");

	// ESC [ opens a CSI sequence with fresh parameters
	a_csi_open: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_ESC && ch == CH_LBRK) |=>
			(phase_q == PH_CSI && idx_q == '0 && params_q[0] == '0))
		else $error("CSI sequence not opened cleanly");
`endif

endmodule

>>> design/terminal_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser
// Console character stream to display actions: input word register, decode
// against the escape parser state, result word register.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while m_axis_tready is high; an accepted
//   input word passes the input register, then a combinational decode that
//   reads and updates the escape state, then the result register to m_axis.
// Reset: arst_n clears the escape state, parameters and standout mode and
//   empties both registers; no words are held across reset.
module terminal_escape_sequence_parser
	import tesp_pkg::*;
#(
	parameter int PARAM_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] char_code, [15:8] cursor_column, [31:16] normal_attr
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] action, [20:5] arg_one, [36:21] arg_two, [44:37] out_char,
	// [60:45] out_attr, [61] scroll_check, [63:62] zero
	output logic [63:0] m_axis_tdata
);

	logic         valid_s1;
	tesp_item_t   item_s1;
	logic         valid_s2;
	tesp_result_t res_s2;
	tesp_result_t res;
	logic         adv;
	logic         fire;
	logic         take;

	// Output register free or draining this cycle
	assign adv           = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	// Hold the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= s_axis_tdata;
		end
	end

	tesp_core #(
		.PARAM_COUNT(PARAM_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.result (res)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2};

`ifndef SYNTHESIS
	// A decoded word always reaches the result register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_axis_tvalid)
		else $error("decoded word lost before the output");
`endif

endmodule
